FILE: sv/twg_pkg.sv
// Shared types and constants for the test waveform generator.
// Holds the multiply-divide unit request/response structs and the sine table function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twg_pkg;

    localparam int MD_M_W = 40;
    localparam int MD_W   = 33;
    localparam int A_W    = 32;
    localparam int STEP_W = 6;

    localparam logic [2:0] MODE_CONST   = 3'd0;
    localparam logic [2:0] MODE_COUNTER = 3'd1;
    localparam logic [2:0] MODE_TOGGLE  = 3'd2;
    localparam logic [2:0] MODE_RANDOM  = 3'd3;
    localparam logic [2:0] MODE_SINE    = 3'd4;
    localparam logic [2:0] MODE_RAMP    = 3'd5;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_MIN      = 3'd1;
    localparam logic [2:0] REG_MAX      = 3'd2;
    localparam logic [2:0] REG_STEP     = 3'd3;
    localparam logic [2:0] REG_PERIOD   = 3'd4;
    localparam logic [2:0] REG_INTERVAL = 3'd5;

    localparam logic [31:0] LFSR_SEED = 32'hACE1_ACE1;
    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [31:0] RST_MAX      = 32'd6553600;
    localparam logic [31:0] RST_STEP     = 32'd65536;
    localparam logic [31:0] RST_PERIOD   = 32'd1000;
    localparam logic [31:0] RST_INTERVAL = 32'd1000;

    localparam logic [17:0]     SINE_BIAS = 18'd65536;
    localparam logic [MD_W-1:0] SINE_DIV  = 33'd131072;
    localparam logic [MD_W-1:0] RAND_DIV  = 33'h1_0000_0000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic              start;
        logic [MD_M_W-1:0] m;
        logic [A_W-1:0]    a;
        logic [MD_W-1:0]   d;
        logic [STEP_W-1:0] steps;
    } t_md_req;

    typedef struct packed {
        logic            done;
        logic [MD_W-1:0] quot;
        logic [MD_W-1:0] rem;
    } t_md_rsp;

    // sin(pi/2 * idx / 2^bits) in Q16, Q30 Taylor series to x^11
    function automatic logic [16:0] sine_q16(int unsigned idx, int unsigned bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned r;
        x    = (HALF_PI_Q30 * longint'(idx)) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = (longint'(sum) + 8192) >> 14;
        if (r > 65536) begin
            r = 65536;
        end
        return r[16:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/twg_muldiv.sv
// Bit-serial multiply-divide unit: quot = floor(M * A / D), rem = (M * A) mod D, M = top steps bits of m.
// One multiplier bit per cycle, MSB first, with up to two conditional subtracts.
// Depends on twg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twg_muldiv import twg_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_md_req i_req,
    output t_md_rsp      o_rsp
);

    logic [MD_M_W-1:0] r_m;
    logic [A_W-1:0]    r_a;
    logic [MD_W-1:0]   r_d;
    logic [MD_W-1:0]   r_rem;
    logic [MD_W-1:0]   r_q;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [MD_W:0]     addend;
    logic [MD_W:0]     acc;
    logic [MD_W+1:0]   diff1;
    logic [MD_W+1:0]   diff2;
    logic [MD_W-1:0]   n_rem;
    logic [1:0]        digit;
    logic [MD_W-1:0]   n_q;

    always_comb begin
        addend = r_m[MD_M_W-1] ? {{(MD_W+1-A_W){1'b0}}, r_a} : '0;
        acc    = {r_rem, 1'b0} + addend;
        diff1  = {1'b0, acc} - {2'b00, r_d};
        diff2  = {1'b0, acc} - {1'b0, r_d, 1'b0};
        if (!diff2[MD_W+1]) begin
            n_rem = diff2[MD_W-1:0];
            digit = 2'd2;
        end else if (!diff1[MD_W+1]) begin
            n_rem = diff1[MD_W-1:0];
            digit = 2'd1;
        end else begin
            n_rem = acc[MD_W-1:0];
            digit = 2'd0;
        end
        n_q = {r_q[MD_W-2:0], 1'b0} + {{(MD_W-2){1'b0}}, digit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_m   <= i_req.m;
            r_a   <= i_req.a;
            r_d   <= i_req.d;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_m   <= {r_m[MD_M_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

FILE: sv/twg_sine_rom.sv
// Quarter-wave sine ROM, 2^TAB_BITS + 1 entries of Q16, registered read.
// Contents built at elaboration. Depends on twg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twg_sine_rom import twg_pkg::*; #(
    parameter int TAB_BITS = 10
) (
    input  wire logic              i_clk,
    input  wire logic [TAB_BITS:0] i_addr,
    output logic [16:0]            o_data
);

    localparam int TAB_DEPTH = (1 << TAB_BITS) + 1;

    typedef logic [16:0] t_tab [TAB_DEPTH];

    function automatic t_tab build_tab();
        t_tab t;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            t[i] = sine_q16(i, TAB_BITS);
        end
        return t;
    endfunction

    localparam t_tab TAB = build_tab();

    logic [16:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: sv/test_waveform_generator_unit.sv
// Waveform generator top level: stream ports, APB register file, sequencer.
// Uses twg_muldiv for modulo, phase and scaling, and twg_sine_rom. Depends on twg_pkg.
// Each input transaction carries now_ms; when at least interval_ms have elapsed since the
// last update, one Q16.16 value is emitted for the selected mode. A tick that does not
// update is accepted without leaving idle. Constant, counter and toggle updates need no pass;
// random makes a scaling pass, ramp a modulo and a scaling pass, sine a modulo, a phase and
// a scaling pass with a table read, all on the shared bit-serial multiply-divide unit (one
// bit per cycle: 40 for now mod period, SINE_TABLE_BITS + 3 for the sine phase, 33 for
// scaling by the range). The input is not ready while an update is in progress; a finished
// value waits in the output register while the next tick is accepted.
`timescale 1ns / 1ps
`default_nettype none

module test_waveform_generator_unit import twg_pkg::*; #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int TIME_BITS       = 40
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // [39:0] now_ms
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] value
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int          TAB_N       = 1 << SINE_TABLE_BITS;
    localparam int          K_W         = SINE_TABLE_BITS + 2;
    localparam int          PAD_W       = MD_M_W - MD_W;
    localparam logic [STEP_W-1:0] MOD_STEPS   = STEP_W'(MD_M_W);
    localparam logic [STEP_W-1:0] PHASE_STEPS = STEP_W'(SINE_TABLE_BITS + 3);
    localparam logic [STEP_W-1:0] SCALE_STEPS = STEP_W'(MD_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_PHASE = 3'd2;
    localparam logic [2:0] S_SINE  = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]           r_mode;
    logic signed [31:0]   r_min;
    logic signed [31:0]   r_max;
    logic signed [31:0]   r_step;
    logic [31:0]          r_period;
    logic [31:0]          r_interval;
    logic signed [31:0]   r_counter;
    logic                 r_toggle;
    logic [TIME_BITS-1:0] r_last;
    logic [31:0]          r_lfsr;
    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic                 r_sneg;
    logic [31:0]          r_result;
    logic                 r_out_valid;
    logic [31:0]          r_out_data;

    logic                 cfg_wr;
    logic [2:0]           cfg_idx;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 in_acc;
    logic                 do_upd;
    logic                 out_free;
    logic [31:0]          per;
    logic signed [32:0]   range;
    logic [MD_W-1:0]      mag;
    logic signed [32:0]   cnt_sum;
    logic signed [31:0]   cnt_next;
    logic [31:0]          lfsr_next;
    logic [K_W-1:0]       k;
    logic [SINE_TABLE_BITS:0] tab_idx;
    logic [16:0]          tab_data;
    logic [17:0]          tab_a;
    logic signed [33:0]   scaled;
    logic [33:0]          q_ext;
    logic [33:0]          value_sum;
    t_md_req              md_req;
    t_md_rsp              md_rsp;

    twg_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    twg_sine_rom #(
        .TAB_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (tab_idx),
        .o_data (tab_data)
    );

    always_comb begin
        cfg_wr   = psel & penable & pwrite;
        cfg_idx  = paddr[4:2];
        now_t    = TIME_BITS'(i_s_axis_tdata);
        elapsed  = now_t - r_last;
        in_acc   = i_s_axis_tvalid & (r_state == S_IDLE);
        do_upd   = in_acc & (elapsed >= TIME_BITS'(r_interval));
        out_free = !r_out_valid | i_m_axis_tready;
        per      = (r_period == 32'd0) ? 32'd1 : r_period;
        range    = 33'(r_max) - 33'(r_min);
        mag      = range[32] ? MD_W'(-range) : MD_W'(range);

        cnt_sum = 33'(r_counter) + 33'(r_step);
        if (cnt_sum > 33'(r_max)) begin
            cnt_next = r_min;
        end else if (cnt_sum[32] & !cnt_sum[31]) begin
            cnt_next = 32'sh8000_0000;
        end else begin
            cnt_next = cnt_sum[31:0];
        end

        lfsr_next = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 32'd0);

        k       = md_rsp.quot[K_W-1:0];
        tab_idx = k[SINE_TABLE_BITS] ?
                  (SINE_TABLE_BITS + 1)'(TAB_N) - {1'b0, k[SINE_TABLE_BITS-1:0]} :
                  {1'b0, k[SINE_TABLE_BITS-1:0]};
        tab_a   = r_sneg ? SINE_BIAS - {1'b0, tab_data} : SINE_BIAS + {1'b0, tab_data};

        q_ext     = {1'b0, md_rsp.quot};
        scaled    = range[32] ? -$signed(q_ext) : $signed(q_ext);
        value_sum = 34'(r_min) + scaled;
    end

    // multiply-divide requests
    always_comb begin
        md_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (do_upd) begin
                    case (r_mode) inside
                        MODE_RANDOM: begin
                            md_req.start = 1'b1;
                            md_req.m     = {mag, {PAD_W{1'b0}}};
                            md_req.a     = lfsr_next;
                            md_req.d     = RAND_DIV;
                            md_req.steps = SCALE_STEPS;
                        end
                        MODE_SINE, MODE_RAMP: begin
                            md_req.start = 1'b1;
                            md_req.m     = MD_M_W'(now_t);
                            md_req.a     = A_W'(1);
                            md_req.d     = {1'b0, per};
                            md_req.steps = MOD_STEPS;
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1;
                    md_req.a     = md_rsp.rem[A_W-1:0];
                    md_req.d     = {1'b0, per};
                    if (r_mode == MODE_RAMP) begin
                        md_req.m     = {mag, {PAD_W{1'b0}}};
                        md_req.steps = SCALE_STEPS;
                    end else begin
                        md_req.m     = {1'b1, {(MD_M_W-1){1'b0}}};
                        md_req.steps = PHASE_STEPS;
                    end
                end
            end
            S_SINE: begin
                md_req.start = 1'b1;
                md_req.m     = {mag, {PAD_W{1'b0}}};
                md_req.a     = A_W'(tab_a);
                md_req.d     = SINE_DIV;
                md_req.steps = SCALE_STEPS;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (do_upd) begin
                    case (r_mode) inside
                        MODE_RANDOM:          n_state = S_SCALE;
                        MODE_SINE, MODE_RAMP: n_state = S_MOD;
                        default:              n_state = S_OUT;
                    endcase
                end
            end
            S_MOD: begin
                if (md_rsp.done) begin
                    n_state = (r_mode == MODE_RAMP) ? S_SCALE : S_PHASE;
                end
            end
            S_PHASE: begin
                if (md_rsp.done) begin
                    n_state = S_SINE;
                end
            end
            S_SINE:  n_state = S_SCALE;
            S_SCALE: begin
                if (md_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_CONST;
            r_min       <= '0;
            r_max       <= RST_MAX;
            r_step      <= RST_STEP;
            r_period    <= RST_PERIOD;
            r_interval  <= RST_INTERVAL;
            r_counter   <= '0;
            r_toggle    <= 1'b0;
            r_last      <= '0;
            r_lfsr      <= LFSR_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_upd) begin
                r_last <= now_t;
                case (r_mode)
                    MODE_COUNTER: r_counter <= cnt_next;
                    MODE_TOGGLE:  r_toggle  <= !r_toggle;
                    MODE_RANDOM:  r_lfsr    <= lfsr_next;
                    default: ;
                endcase
            end
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_MODE:     r_mode     <= pwdata[2:0];
                    REG_MIN: begin
                        r_min     <= pwdata;
                        r_counter <= pwdata;
                    end
                    REG_MAX:      r_max      <= pwdata;
                    REG_STEP:     r_step     <= pwdata;
                    REG_PERIOD:   r_period   <= pwdata;
                    REG_INTERVAL: r_interval <= pwdata;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && do_upd) begin
            case (r_mode)
                MODE_COUNTER: r_result <= cnt_next;
                MODE_TOGGLE:  r_result <= r_toggle ? r_min : r_max;
                default:      r_result <= r_min;
            endcase
        end else if (r_state == S_SCALE && md_rsp.done) begin
            r_result <= value_sum[31:0];
        end
        if (r_state == S_PHASE && md_rsp.done) begin
            r_sneg <= k[SINE_TABLE_BITS+1];
        end
        if (r_state == S_OUT && out_free) begin
            r_out_data <= r_result;
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MODE:     prdata = {29'd0, r_mode};
            REG_MIN:      prdata = r_min;
            REG_MAX:      prdata = r_max;
            REG_STEP:     prdata = r_step;
            REG_PERIOD:   prdata = r_period;
            REG_INTERVAL: prdata = r_interval;
            default:      prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
